// ===== hdl/gmp_pkg.sv =====
// ============================================================================
// Grid maze path search package
// Shared sizes, command and status structs, and the side clamp function.
// ============================================================================
package gmp_pkg;

    localparam int MAX_SIDE    = 16;
    localparam int IDX_W       = $clog2(MAX_SIDE);
    localparam int CELL_W      = 2 * IDX_W;
    localparam int CELL_COUNT  = MAX_SIDE * MAX_SIDE;
    localparam int STACK_DEPTH = 2 * MAX_SIDE;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int SIDE_CFG_W  = 5;

    localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = SIDE_CFG_W'(MAX_SIDE);

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_SOLVE = 1'b1;

    typedef struct packed {
        logic maze_wr;
        logic solve_init;
        logic clear_step;
        logic rd_start;
        logic rd_down;
        logic rd_right;
        logic push_start;
        logic push_down;
        logic push_right;
        logic pop;
        logic load_top;
        logic emit_word;
        logic emit_fail;
    } gmp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic cell_ok;
        logic at_target;
        logic can_down;
        logic can_right;
        logic depth_one;
        logic emit_last;
        logic out_free;
    } gmp_sts_t;

    // A side of zero counts as one, and a side above the maximum is saturated.
    function automatic logic [IDX_W-1:0] side_m1_of(input logic [SIDE_CFG_W-1:0] side);
        logic [IDX_W-1:0] res;
        if (side == '0)
        begin
            res = '0;
        end
        else if (side > SIDE_CFG_W'(MAX_SIDE))
        begin
            res = IDX_W'(MAX_SIDE - 1);
        end
        else
        begin
            res = IDX_W'(side - SIDE_CFG_W'(1));
        end
        return res;
    endfunction

endpackage

// ===== hdl/gmp_if.sv =====
// ============================================================================
// Grid maze path search channels
// Valid/ready interfaces for the input, result and configuration channels.
// ============================================================================
interface gmp_in_if;
    import gmp_pkg::*;

    logic             valid;
    logic             ready;
    logic             action;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             open;

    modport source (output valid, action, row, col, open, input ready);
    modport sink (input valid, action, row, col, open, output ready);
endinterface

interface gmp_out_if;
    import gmp_pkg::*;

    logic                valid;
    logic                ready;
    logic                found;
    logic [IDX_W-1:0]    row_index;
    logic [MAX_SIDE-1:0] row_bits;
    logic                last;

    modport source (output valid, found, row_index, row_bits, last, input ready);
    modport sink (input valid, found, row_index, row_bits, last, output ready);
endinterface

interface gmp_cfg_if;
    import gmp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SIDE_CFG_W-1:0] grid_side;

    modport source (output valid, grid_side, input ready);
    modport sink (input valid, grid_side, output ready);
endinterface

// ===== hdl/gmp_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module gmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/gmp_ctrl.sv =====
// ============================================================================
// Grid maze path search controller
// Sequences loading, the dead map clear, the down-then-right search and output.
// ============================================================================
module gmp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_action,
    output logic              in_ready,
    input  gmp_pkg::gmp_sts_t sts,
    output gmp_pkg::gmp_cmd_t cmd
);
    import gmp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_CHK0,
        S_TOP,
        S_CHKD,
        S_CHKR,
        S_POPW,
        S_EMIT,
        S_FAIL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_action == ACT_SOLVE)
                    begin
                        cmd.solve_init = 1'b1;
                        state_next     = S_CLEAR;
                    end
                    else
                    begin
                        cmd.maze_wr = 1'b1;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    cmd.rd_start = 1'b1;
                    state_next   = S_CHK0;
                end
            end
            S_CHK0:
            begin
                if (sts.cell_ok)
                begin
                    cmd.push_start = 1'b1;
                    state_next     = S_TOP;
                end
                else
                begin
                    state_next = S_FAIL;
                end
            end
            S_TOP:
            begin
                if (sts.at_target)
                begin
                    state_next = S_EMIT;
                end
                else if (sts.can_down)
                begin
                    cmd.rd_down = 1'b1;
                    state_next  = S_CHKD;
                end
                else if (sts.can_right)
                begin
                    cmd.rd_right = 1'b1;
                    state_next   = S_CHKR;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = sts.depth_one ? S_FAIL : S_POPW;
                end
            end
            S_CHKD:
            begin
                if (sts.cell_ok)
                begin
                    cmd.push_down = 1'b1;
                    state_next    = S_TOP;
                end
                else if (sts.can_right)
                begin
                    cmd.rd_right = 1'b1;
                    state_next   = S_CHKR;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = sts.depth_one ? S_FAIL : S_POPW;
                end
            end
            S_CHKR:
            begin
                if (sts.cell_ok)
                begin
                    cmd.push_right = 1'b1;
                    state_next     = S_TOP;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = sts.depth_one ? S_FAIL : S_POPW;
                end
            end
            S_POPW:
            begin
                cmd.load_top = 1'b1;
                state_next   = S_TOP;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_word = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FAIL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_fail = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/gmp_dp.sv =====
// ============================================================================
// Grid maze path search datapath
// Maze, dead map and walk stack memories, path bits, side register and output.
// ============================================================================
module gmp_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [gmp_pkg::IDX_W-1:0]        in_row,
    input  logic [gmp_pkg::IDX_W-1:0]        in_col,
    input  logic                             in_open,
    input  logic                             cfg_valid,
    input  logic [gmp_pkg::SIDE_CFG_W-1:0]   cfg_grid_side,
    input  gmp_pkg::gmp_cmd_t                cmd,
    output gmp_pkg::gmp_sts_t                sts,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic                             out_found,
    output logic [gmp_pkg::IDX_W-1:0]        out_row_index,
    output logic [gmp_pkg::MAX_SIDE-1:0]     out_row_bits,
    output logic                             out_last
);
    import gmp_pkg::*;

    logic [SIDE_CFG_W-1:0] grid_side_reg, grid_side_next;
    logic [IDX_W-1:0]      side_m1_reg, side_m1_next;
    logic [IDX_W-1:0]      cur_r_reg, cur_r_next;
    logic [IDX_W-1:0]      cur_c_reg, cur_c_next;
    logic [STACK_AW-1:0]   depth_reg, depth_next;
    logic [CELL_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]      emit_idx_reg, emit_idx_next;
    logic [MAX_SIDE-1:0]   path_reg [MAX_SIDE];
    logic [MAX_SIDE-1:0]   path_next [MAX_SIDE];
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg, out_found_next;
    logic [IDX_W-1:0]      out_row_index_reg, out_row_index_next;
    logic [MAX_SIDE-1:0]   out_row_bits_reg, out_row_bits_next;
    logic                  out_last_reg, out_last_next;

    logic [IDX_W-1:0]    down_r;
    logic [IDX_W-1:0]    right_c;
    logic [IDX_W-1:0]    new_r;
    logic [IDX_W-1:0]    new_c;
    logic                push;
    logic [CELL_W-1:0]   probe_addr;
    logic                maze_q;
    logic                dead_we;
    logic [CELL_W-1:0]   dead_waddr;
    logic                dead_q;
    logic [CELL_W-1:0]   stack_q;

    assign down_r  = cur_r_reg + IDX_W'(1);
    assign right_c = cur_c_reg + IDX_W'(1);
    assign push    = cmd.push_start | cmd.push_down | cmd.push_right;

    always_comb
    begin
        if (cmd.push_start)
        begin
            new_r = '0;
            new_c = '0;
        end
        else if (cmd.push_down)
        begin
            new_r = down_r;
            new_c = cur_c_reg;
        end
        else
        begin
            new_r = cur_r_reg;
            new_c = right_c;
        end
    end

    always_comb
    begin
        if (cmd.rd_start)
        begin
            probe_addr = '0;
        end
        else if (cmd.rd_down)
        begin
            probe_addr = {down_r, cur_c_reg};
        end
        else if (cmd.rd_right)
        begin
            probe_addr = {cur_r_reg, right_c};
        end
        else
        begin
            probe_addr = {cur_r_reg, cur_c_reg};
        end
    end

    assign dead_we    = cmd.clear_step | cmd.pop;
    assign dead_waddr = cmd.clear_step ? clr_addr_reg : {cur_r_reg, cur_c_reg};

    gmp_ram #(
        .WIDTH (1),
        .DEPTH (CELL_COUNT)
    ) u_maze_ram (
        .clk   (clk),
        .we    (cmd.maze_wr),
        .waddr ({in_row, in_col}),
        .wdata (in_open),
        .raddr (probe_addr),
        .rdata (maze_q)
    );

    gmp_ram #(
        .WIDTH (1),
        .DEPTH (CELL_COUNT)
    ) u_dead_ram (
        .clk   (clk),
        .we    (dead_we),
        .waddr (dead_waddr),
        .wdata (cmd.pop),
        .raddr (probe_addr),
        .rdata (dead_q)
    );

    gmp_ram #(
        .WIDTH (CELL_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (push),
        .waddr (depth_reg),
        .wdata ({new_r, new_c}),
        .raddr (depth_reg - STACK_AW'(2)),
        .rdata (stack_q)
    );

    always_comb
    begin
        grid_side_next     = grid_side_reg;
        side_m1_next       = side_m1_reg;
        cur_r_next         = cur_r_reg;
        cur_c_next         = cur_c_reg;
        depth_next         = depth_reg;
        clr_addr_next      = clr_addr_reg;
        emit_idx_next      = emit_idx_reg;
        path_next          = path_reg;
        out_valid_next     = out_valid_reg;
        out_found_next     = out_found_reg;
        out_row_index_next = out_row_index_reg;
        out_row_bits_next  = out_row_bits_reg;
        out_last_next      = out_last_reg;

        if (cfg_valid)
        begin
            grid_side_next = cfg_grid_side;
        end

        if (cmd.solve_init)
        begin
            side_m1_next  = side_m1_of(grid_side_reg);
            depth_next    = '0;
            clr_addr_next = '0;
            emit_idx_next = '0;
            for (int i = 0; i < MAX_SIDE; i++)
            begin
                path_next[i] = '0;
            end
        end

        if (cmd.clear_step)
        begin
            clr_addr_next = clr_addr_reg + CELL_W'(1);
        end

        if (push)
        begin
            cur_r_next               = new_r;
            cur_c_next               = new_c;
            depth_next               = depth_reg + STACK_AW'(1);
            path_next[new_r][new_c]  = 1'b1;
        end

        if (cmd.pop)
        begin
            depth_next                      = depth_reg - STACK_AW'(1);
            path_next[cur_r_reg][cur_c_reg] = 1'b0;
        end

        if (cmd.load_top)
        begin
            cur_r_next = stack_q[CELL_W-1:IDX_W];
            cur_c_next = stack_q[IDX_W-1:0];
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit_word)
        begin
            out_valid_next     = 1'b1;
            out_found_next     = 1'b1;
            out_row_index_next = emit_idx_reg;
            out_row_bits_next  = path_reg[emit_idx_reg];
            out_last_next      = (emit_idx_reg == side_m1_reg);
            emit_idx_next      = emit_idx_reg + IDX_W'(1);
        end
        else if (cmd.emit_fail)
        begin
            out_valid_next     = 1'b1;
            out_found_next     = 1'b0;
            out_row_index_next = '0;
            out_row_bits_next  = '0;
            out_last_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg <= SIDE_RESET;
            out_valid_reg <= 1'b0;
            depth_reg     <= '0;
        end
        else
        begin
            grid_side_reg <= grid_side_next;
            out_valid_reg <= out_valid_next;
            depth_reg     <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_m1_reg       <= side_m1_next;
        cur_r_reg         <= cur_r_next;
        cur_c_reg         <= cur_c_next;
        clr_addr_reg      <= clr_addr_next;
        emit_idx_reg      <= emit_idx_next;
        path_reg          <= path_next;
        out_found_reg     <= out_found_next;
        out_row_index_reg <= out_row_index_next;
        out_row_bits_reg  <= out_row_bits_next;
        out_last_reg      <= out_last_next;
    end

    assign sts.clear_done = &clr_addr_reg;
    assign sts.cell_ok    = maze_q & ~dead_q;
    assign sts.at_target  = (cur_r_reg == side_m1_reg) && (cur_c_reg == side_m1_reg);
    assign sts.can_down   = cur_r_reg < side_m1_reg;
    assign sts.can_right  = cur_c_reg < side_m1_reg;
    assign sts.depth_one  = depth_reg == STACK_AW'(1);
    assign sts.emit_last  = emit_idx_reg == side_m1_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_found     = out_found_reg;
    assign out_row_index = out_row_index_reg;
    assign out_row_bits  = out_row_bits_reg;
    assign out_last      = out_last_reg;

endmodule

// ===== hdl/grid_maze_path_search.sv =====
// ============================================================================
// Grid maze path search
// Down-then-right backtracking search from the top-left to the bottom-right cell.
// ============================================================================
// The cmd channel carries one word per action. A load word writes the open bit
// of one maze cell. A solve word starts a search over the square of side
// grid_side, which the user must write on the cfg channel while the block is
// idle; the block itself does not enforce this (cfg is always ready; reset
// value 16). A solve first clears all 256 cells of the dead-cell map, one cell
// per cycle. The search then proceeds in steps, where a step pushes a cell or
// backs out of one; a path takes at least 2*side-1 pushes.
// Results leave on the rsp channel: side words, one per row with the path
// bits, last set on the final one, or a single word with found clear.
// One result word per cycle is sent when the receiver is ready. While it
// stalls, the word is held in the output register, and once the last word of
// a solve sits there the cmd channel is ready again.
// Reset returns the controller and the output register to idle and grid_side
// to 16; maze cells must be loaded before use.
// ============================================================================
module grid_maze_path_search (
    input logic        clk,
    input logic        rst_n,
    gmp_in_if.sink     cmd,
    gmp_out_if.source  rsp,
    gmp_cfg_if.sink    cfg
);
    import gmp_pkg::*;

    gmp_cmd_t ctl_cmd;
    gmp_sts_t ctl_sts;

    assign cfg.ready = 1'b1;

    gmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_action (cmd.action),
        .in_ready  (cmd.ready),
        .sts       (ctl_sts),
        .cmd       (ctl_cmd)
    );

    gmp_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_row        (cmd.row),
        .in_col        (cmd.col),
        .in_open       (cmd.open),
        .cfg_valid     (cfg.valid),
        .cfg_grid_side (cfg.grid_side),
        .cmd           (ctl_cmd),
        .sts           (ctl_sts),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .out_found     (rsp.found),
        .out_row_index (rsp.row_index),
        .out_row_bits  (rsp.row_bits),
        .out_last      (rsp.last)
    );

`ifndef SYNTHESIS
    // A solve occupies the block, so no word is taken in the cycle after it.
    a_solve_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.action == ACT_SOLVE) |=> !cmd.ready)
        else $error("cmd accepted right after a solve");

    // The controller only loads a result word when the output register is free.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_cmd.emit_word || ctl_cmd.emit_fail) |-> ctl_sts.out_free)
        else $error("result word overwritten");

    // A search without a path reports a single empty last word.
    a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> (rsp.last && rsp.row_bits == '0))
        else $error("malformed no-path word");
`endif

endmodule
